// ----- src/rtp_stream_demux_filter_core_assert.svh -----
// Assertion macros used by the filter RTL.
`ifndef RTP_STREAM_DEMUX_FILTER_CORE_ASSERT_SVH
`define RTP_STREAM_DEMUX_FILTER_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define RSDF_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define RSDF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/rsdf_pkg.sv -----
`default_nettype none

package rsdf_pkg;

    localparam int BOUND_ENTRIES  = 16;
    localparam int REMOTE_ENTRIES = 16;
    localparam int MAX_ENTRIES    = (BOUND_ENTRIES > REMOTE_ENTRIES) ?
                                    BOUND_ENTRIES : REMOTE_ENTRIES;

    localparam int B_IDX_W = (BOUND_ENTRIES > 1)  ? $clog2(BOUND_ENTRIES)  : 1;
    localparam int R_IDX_W = (REMOTE_ENTRIES > 1) ? $clog2(REMOTE_ENTRIES) : 1;
    localparam int IDX_W   = (MAX_ENTRIES > 1)    ? $clog2(MAX_ENTRIES)    : 1;
    localparam int CNT_W   = $clog2(MAX_ENTRIES + 1);

    localparam int SSRC_W     = 32;
    localparam int PT_W       = 7;
    localparam int MID_W      = 64;
    localparam int MASK_W     = 64;
    localparam int IN_W       = 168;  // ssrc, pt, mid_present, mid_hi, mid_lo
    localparam int OUT_W      = 8;    // pass, reason, overflow, zero pad
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MID_VALID   = 3'd0,
        CFG_MID_HI      = 3'd1,
        CFG_MID_LO      = 3'd2,
        CFG_PT_MASK_HI  = 3'd3,
        CFG_PT_MASK_LO  = 3'd4
    } t_cfg_reg;

    typedef enum logic [1:0] {
        REASON_NONE   = 2'd0,
        REASON_MID    = 2'd1,
        REASON_REMOTE = 2'd2,
        REASON_PT     = 2'd3
    } t_reason;

    typedef enum logic [2:0] {
        S_IDLE,
        S_BSCAN,
        S_BUPD,
        S_RSCAN,
        S_RUPD,
        S_DONE
    } t_state;

    // Accumulated result of one table scan.
    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] found_idx;
        logic             free;
        logic [IDX_W-1:0] free_idx;
        logic             other;     // a valid entry holding a different SSRC
    } t_scan_res;

endpackage

`default_nettype wire

// ----- src/rsdf_match_unit.sv -----
`default_nettype none

// Shared SSRC compare unit: one table entry per step, results accumulated.
module rsdf_match_unit (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_clr,
    input  wire logic                        i_step,
    input  wire logic [rsdf_pkg::IDX_W-1:0]  i_idx,
    input  wire logic                        i_ent_valid,
    input  wire logic [rsdf_pkg::SSRC_W-1:0] i_ent_ssrc,
    input  wire logic [rsdf_pkg::SSRC_W-1:0] i_key,
    output rsdf_pkg::t_scan_res              o_res
);

    rsdf_pkg::t_scan_res r_res;
    logic                hit;

    assign hit = i_ent_valid && (i_ent_ssrc == i_key);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clr) begin
            r_res <= '0;
        end else if (i_step) begin
            if (hit && !r_res.found) begin
                r_res.found     <= 1'b1;
                r_res.found_idx <= i_idx;
            end
            if (!i_ent_valid && !r_res.free) begin
                r_res.free     <= 1'b1;
                r_res.free_idx <= i_idx;
            end
            if (i_ent_valid && !hit) begin
                r_res.other <= 1'b1;
            end
        end
    end

    assign o_res = r_res;

endmodule

`default_nettype wire

// ----- src/rtp_stream_demux_filter_core.sv -----
// RTP stream demux filter.
// Input stream: one transaction per RTP header (tuser = func: 0 filter a packet,
// 1 add a negotiated remote SSRC). tdata carries ssrc, payload type, MID flag
// and the 128-bit packet MID. Output stream: one transaction per input, with
// pass, match reason and a table-overflow flag.
// Config channel: index/data writes to the MID and payload-type mask registers;
// issue them only while the block is idle. Writing any MID register drops all
// bindings. o_cfg_ready is always high.
// Timing: tready is high only in the idle state, so a new header is accepted only
// after the previous one has reached its result. A filter request scans the
// bound table and, when no binding settles it, then the remote table; an add
// request scans the remote table only. Each scan uses the single SSRC comparator,
// which walks its table one entry per cycle. The result passes from the final
// decision state through the DONE state into the output register.
// Output is a register: the next header is accepted while a result waits, and
// a stalled receiver holds the sequencer in its final state until the slot frees.
// Reset (synchronous, active low) empties both tables and clears the control and config registers.
`default_nettype none
`include "rtp_stream_demux_filter_core_assert.svh"

module rtp_stream_demux_filter_core (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // slave stream
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    // tdata: [31:0] ssrc, [38:32] pt, [39] mid_present,
    //        [103:40] mid_hi, [167:104] mid_lo
    input  wire logic [rsdf_pkg::IN_W-1:0]       s_axis_tdata,
    // tuser: [0] func
    input  wire logic [0:0]                      s_axis_tuser,
    // master stream
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // tdata: [0] pass, [2:1] match_reason, [3] table_overflow, [7:4] zero
    output logic [rsdf_pkg::OUT_W-1:0]           m_axis_tdata,
    // config write channel
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [rsdf_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [rsdf_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int B_N = rsdf_pkg::BOUND_ENTRIES;
    localparam int R_N = rsdf_pkg::REMOTE_ENTRIES;

    // configuration
    logic                          r_mid_valid;
    logic [rsdf_pkg::MID_W-1:0]    r_mid_hi;
    logic [rsdf_pkg::MID_W-1:0]    r_mid_lo;
    logic [rsdf_pkg::MASK_W-1:0]   r_pt_hi;
    logic [rsdf_pkg::MASK_W-1:0]   r_pt_lo;

    // tables
    logic [B_N-1:0]                r_bnd_valid;
    logic [rsdf_pkg::SSRC_W-1:0]   r_bnd_ssrc [B_N];
    logic [R_N-1:0]                r_rem_valid;
    logic [rsdf_pkg::SSRC_W-1:0]   r_rem_ssrc [R_N];

    // item being worked on
    rsdf_pkg::t_state              r_state, n_state;
    logic [rsdf_pkg::CNT_W-1:0]    r_cnt, n_cnt;
    logic                          r_func;
    logic [rsdf_pkg::SSRC_W-1:0]   r_ssrc;
    logic                          r_mid_present;
    logic                          r_mid_match;
    logic                          r_pt_ok;
    logic                          r_pass, n_pass;
    rsdf_pkg::t_reason             r_reason, n_reason;
    logic                          r_ovf, n_ovf;

    // output slot
    logic                          r_out_valid, n_out_valid;
    logic [rsdf_pkg::OUT_W-1:0]    r_out_data, n_out_data;

    // handshakes
    logic                          in_acc;
    logic                          cfg_acc;
    logic                          mid_wr;

    // compare unit
    logic                          scan_clr;
    logic                          scan_step;
    logic                          ent_valid;
    logic [rsdf_pkg::SSRC_W-1:0]   ent_ssrc;
    rsdf_pkg::t_scan_res           scan_res;

    // table writes
    logic                          bnd_wr;
    logic                          bnd_wr_val;
    logic [rsdf_pkg::B_IDX_W-1:0]  bnd_wr_idx;
    logic                          rem_wr;
    logic [rsdf_pkg::R_IDX_W-1:0]  rem_wr_idx;

    // decode of the incoming header
    logic [rsdf_pkg::SSRC_W-1:0]   in_ssrc;
    logic [rsdf_pkg::PT_W-1:0]     in_pt;
    logic                          in_mid_present;
    logic [rsdf_pkg::MID_W-1:0]    in_mid_hi;
    logic [rsdf_pkg::MID_W-1:0]    in_mid_lo;
    logic                          in_pt_ok;

    assign in_ssrc        = s_axis_tdata[31:0];
    assign in_pt          = s_axis_tdata[38:32];
    assign in_mid_present = s_axis_tdata[39];
    assign in_mid_hi      = s_axis_tdata[103:40];
    assign in_mid_lo      = s_axis_tdata[167:104];
    assign in_pt_ok       = in_pt[6] ? r_pt_hi[in_pt[5:0]] : r_pt_lo[in_pt[5:0]];

    assign s_axis_tready = (r_state == rsdf_pkg::S_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;
    assign cfg_acc       = i_cfg_valid && o_cfg_ready;
    assign mid_wr        = cfg_acc && ((i_cfg_index == rsdf_pkg::CFG_MID_VALID) ||
                                       (i_cfg_index == rsdf_pkg::CFG_MID_HI) ||
                                       (i_cfg_index == rsdf_pkg::CFG_MID_LO));

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // entry under the comparator: bound table in its scan, remote otherwise
    always_comb begin
        if (r_state == rsdf_pkg::S_BSCAN) begin
            ent_valid = r_bnd_valid[r_cnt[rsdf_pkg::B_IDX_W-1:0]];
            ent_ssrc  = r_bnd_ssrc[r_cnt[rsdf_pkg::B_IDX_W-1:0]];
        end else begin
            ent_valid = r_rem_valid[r_cnt[rsdf_pkg::R_IDX_W-1:0]];
            ent_ssrc  = r_rem_ssrc[r_cnt[rsdf_pkg::R_IDX_W-1:0]];
        end
    end

    rsdf_match_unit u_match (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_clr       (scan_clr),
        .i_step      (scan_step),
        .i_idx       (r_cnt[rsdf_pkg::IDX_W-1:0]),
        .i_ent_valid (ent_valid),
        .i_ent_ssrc  (ent_ssrc),
        .i_key       (r_ssrc),
        .o_res       (scan_res)
    );

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mid_valid <= 1'b0;
            r_mid_hi    <= '0;
            r_mid_lo    <= '0;
            r_pt_hi     <= '0;
            r_pt_lo     <= '0;
        end else if (cfg_acc) begin
            case (i_cfg_index)
                rsdf_pkg::CFG_MID_VALID:  r_mid_valid <= i_cfg_data[0];
                rsdf_pkg::CFG_MID_HI:     r_mid_hi    <= i_cfg_data;
                rsdf_pkg::CFG_MID_LO:     r_mid_lo    <= i_cfg_data;
                rsdf_pkg::CFG_PT_MASK_HI: r_pt_hi     <= i_cfg_data;
                rsdf_pkg::CFG_PT_MASK_LO: r_pt_lo     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // table storage; valid bits reset, SSRC payload does not
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bnd_valid <= '0;
            r_rem_valid <= '0;
        end else begin
            // a new MID invalidates all bindings (writes must come only while idle; not enforced here)
            if (mid_wr) begin
                r_bnd_valid <= '0;
            end else if (bnd_wr) begin
                r_bnd_valid[bnd_wr_idx] <= bnd_wr_val;
            end
            if (rem_wr) begin
                r_rem_valid[rem_wr_idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (bnd_wr && bnd_wr_val) begin
            r_bnd_ssrc[bnd_wr_idx] <= r_ssrc;
        end
        if (rem_wr) begin
            r_rem_ssrc[rem_wr_idx] <= r_ssrc;
        end
    end

    // latch the header at accept; MID compare and PT lookup happen here
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_func        <= s_axis_tuser[0];
            r_ssrc        <= in_ssrc;
            r_mid_present <= in_mid_present;
            r_mid_match   <= in_mid_present && r_mid_valid &&
                             (in_mid_hi == r_mid_hi) && (in_mid_lo == r_mid_lo);
            r_pt_ok       <= in_pt_ok;
        end
        r_out_data <= n_out_data;
    end

    // sequencer registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rsdf_pkg::S_IDLE;
            r_cnt       <= '0;
            r_pass      <= 1'b0;
            r_reason    <= rsdf_pkg::REASON_NONE;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_pass      <= n_pass;
            r_reason    <= n_reason;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
        end
    end

    // sequencer: next state, compare unit control, table updates, result
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_pass      = r_pass;
        n_reason    = r_reason;
        n_ovf       = r_ovf;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_data  = r_out_data;
        scan_clr    = 1'b0;
        scan_step   = 1'b0;
        bnd_wr      = 1'b0;
        bnd_wr_val  = 1'b0;
        bnd_wr_idx  = scan_res.found_idx[rsdf_pkg::B_IDX_W-1:0];
        rem_wr      = 1'b0;
        rem_wr_idx  = scan_res.free_idx[rsdf_pkg::R_IDX_W-1:0];

        case (r_state)
            rsdf_pkg::S_IDLE: begin
                if (in_acc) begin
                    scan_clr = 1'b1;
                    n_cnt    = '0;
                    n_pass   = 1'b0;
                    n_reason = rsdf_pkg::REASON_NONE;
                    n_ovf    = 1'b0;
                    n_state  = s_axis_tuser[0] ? rsdf_pkg::S_RSCAN : rsdf_pkg::S_BSCAN;
                end
            end

            rsdf_pkg::S_BSCAN: begin
                scan_step = 1'b1;
                if (r_cnt == rsdf_pkg::CNT_W'(B_N - 1)) begin
                    n_state = rsdf_pkg::S_BUPD;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end

            rsdf_pkg::S_BUPD: begin
                // SSRCs are unique in a table, so "other" means another binding
                if (scan_res.found && r_mid_present && !r_mid_match) begin
                    // bound SSRC moved to another MID: unbind
                    bnd_wr     = 1'b1;
                    bnd_wr_val = 1'b0;
                    n_state    = scan_res.other ? rsdf_pkg::S_DONE : rsdf_pkg::S_RSCAN;
                end else if (r_mid_match) begin
                    n_state = rsdf_pkg::S_DONE;
                    if (scan_res.found) begin
                        n_pass   = 1'b1;
                        n_reason = rsdf_pkg::REASON_MID;
                    end else if (scan_res.free) begin
                        bnd_wr     = 1'b1;
                        bnd_wr_val = 1'b1;
                        bnd_wr_idx = scan_res.free_idx[rsdf_pkg::B_IDX_W-1:0];
                        n_pass     = 1'b1;
                        n_reason   = rsdf_pkg::REASON_MID;
                    end else begin
                        // full table: bindings exist, this SSRC is not one
                        n_ovf = 1'b1;
                    end
                end else if (scan_res.found || scan_res.other) begin
                    n_state = rsdf_pkg::S_DONE;
                    if (scan_res.found) begin
                        n_pass   = 1'b1;
                        n_reason = rsdf_pkg::REASON_MID;
                    end
                end else begin
                    n_state = rsdf_pkg::S_RSCAN;
                end
                if (n_state == rsdf_pkg::S_RSCAN) begin
                    scan_clr = 1'b1;
                    n_cnt    = '0;
                end
            end

            rsdf_pkg::S_RSCAN: begin
                scan_step = 1'b1;
                if (r_cnt == rsdf_pkg::CNT_W'(R_N - 1)) begin
                    n_state = rsdf_pkg::S_RUPD;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end

            rsdf_pkg::S_RUPD: begin
                n_state = rsdf_pkg::S_DONE;
                if (r_func) begin
                    if (!scan_res.found) begin
                        rem_wr = scan_res.free;
                        n_ovf  = !scan_res.free;
                    end
                end else if (scan_res.found) begin
                    n_pass   = 1'b1;
                    n_reason = rsdf_pkg::REASON_REMOTE;
                end else if (r_pt_ok) begin
                    rem_wr   = scan_res.free;
                    n_ovf    = !scan_res.free;
                    n_pass   = 1'b1;
                    n_reason = rsdf_pkg::REASON_PT;
                end
            end

            rsdf_pkg::S_DONE: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = {4'b0000, r_ovf, r_reason, r_pass};
                    n_state     = rsdf_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = rsdf_pkg::S_IDLE;
            end
        endcase
    end

    // checks
    `RSDF_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n,
        in_acc, !s_axis_tready, "input accepted while sequencer busy")
    `RSDF_ASSERT_NOW(a_pass_has_reason, i_clk, i_rst_n,
        m_axis_tvalid, m_axis_tdata[0] == (m_axis_tdata[2:1] != 2'b00),
        "pass and match reason disagree")
    `RSDF_ASSERT_NEXT(a_mid_write_unbinds, i_clk, i_rst_n,
        mid_wr, r_bnd_valid == '0, "MID write left a binding")
    `RSDF_ASSERT_NOW(a_bupd_after_scan, i_clk, i_rst_n,
        r_state == rsdf_pkg::S_BUPD, $past(r_state) == rsdf_pkg::S_BSCAN,
        "bound update without a full scan")

endmodule

`default_nettype wire

// ----- tb/sv/testbench.sv -----
`default_nettype none

module testbench;
    import rsdf_pkg::*;

    // input item and result, field by field
    typedef struct packed {
        logic              func;
        logic [SSRC_W-1:0] ssrc;
        logic [PT_W-1:0]   pt;
        logic              mid_present;
        logic [MID_W-1:0]  mid_hi;
        logic [MID_W-1:0]  mid_lo;
    } t_hdr;

    typedef struct packed {
        logic    pass;
        t_reason reason;
        logic    ovf;
    } t_verdict;

    localparam logic FUNC_FILTER     = 1'b0;
    localparam logic FUNC_ADD_REMOTE = 1'b1;

    localparam int TBL_BOUND  = 0;
    localparam int TBL_REMOTE = 1;

    localparam int N_PHASES       = 9;
    localparam int PHASE_ITEMS    = 210;
    localparam int HOLD_PHASE     = 4;
    localparam int RX_HOLD_CYCLES = 500;
    localparam int SSRC_POOL      = 24;
    localparam int SETTLE_CYCLES  = 4;
    localparam int TAIL_CYCLES    = 40;
    localparam int MAX_REPORTS    = 100;

    localparam logic [MID_W-1:0] ALL_ONES = '1;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_W-1:0]       s_axis_tdata  = '0;
    logic [0:0]            s_axis_tuser  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_W-1:0]      m_axis_tdata;
    logic                  i_cfg_valid   = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index   = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data    = '0;

    rtp_stream_demux_filter_core DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // Filter state as the testbench sees it: registers and both tables
    // ---------------------------------------------------------------
    logic             mid_vld_cfg    = 1'b0;
    logic [MID_W-1:0] mid_hi_cfg     = '0;
    logic [MID_W-1:0] mid_lo_cfg     = '0;
    logic [MASK_W-1:0] pt_mask_hi_cfg = '0;
    logic [MASK_W-1:0] pt_mask_lo_cfg = '0;

    bit              tbl_vld  [2][MAX_ENTRIES];
    bit [SSRC_W-1:0] tbl_ssrc [2][MAX_ENTRIES];

    t_hdr     hdr_q[$];      // headers waiting to be sent
    t_verdict verdict_q[$];  // verdicts owed by the block, oldest first
    t_hdr     tx_hdr;
    t_verdict mon_exp;

    logic [SSRC_W-1:0] ssrc_pool [SSRC_POOL];

    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    int rx_hold_left = 0;
    logic rx_hold_go = 1'b0;
    int err_cnt = 0;
    int res_cnt = 0;

    function automatic int tbl_lookup(int t, logic [SSRC_W-1:0] s);
        int depth;
        depth = (t == TBL_BOUND) ? BOUND_ENTRIES : REMOTE_ENTRIES;
        for (int i = 0; i < depth; i++)
            if (tbl_vld[t][i] && tbl_ssrc[t][i] == s)
                return i;
        return -1;
    endfunction

    // returns 1 when the table was full and the insert got dropped
    function automatic bit tbl_add(int t, logic [SSRC_W-1:0] s);
        int depth;
        depth = (t == TBL_BOUND) ? BOUND_ENTRIES : REMOTE_ENTRIES;
        if (tbl_lookup(t, s) >= 0)
            return 1'b0;
        for (int i = 0; i < depth; i++)
            if (!tbl_vld[t][i]) begin
                tbl_vld[t][i]  = 1'b1;
                tbl_ssrc[t][i] = s;
                return 1'b0;
            end
        return 1'b1;
    endfunction

    // Works out the verdict for one header and updates the tables.
    function automatic t_verdict filter_decide(t_hdr h);
        t_verdict v;
        int       hit;
        bit       mid_hit;
        bit       any_bound;
        bit       pt_ok;
        v.pass   = 1'b0;
        v.reason = REASON_NONE;
        v.ovf    = 1'b0;
        if (h.func == FUNC_ADD_REMOTE) begin
            v.ovf = tbl_add(TBL_REMOTE, h.ssrc);
            return v;
        end
        // MID only counts when both sides actually have one
        mid_hit = h.mid_present && mid_vld_cfg &&
                  h.mid_hi == mid_hi_cfg && h.mid_lo == mid_lo_cfg;
        hit = tbl_lookup(TBL_BOUND, h.ssrc);
        if (hit >= 0 && h.mid_present && !mid_hit)
            tbl_vld[TBL_BOUND][hit] = 1'b0;
        if (mid_hit && tbl_add(TBL_BOUND, h.ssrc))
            v.ovf = 1'b1;
        any_bound = 1'b0;
        for (int i = 0; i < BOUND_ENTRIES; i++)
            any_bound |= tbl_vld[TBL_BOUND][i];
        if (any_bound) begin
            if (tbl_lookup(TBL_BOUND, h.ssrc) >= 0) begin
                v.pass   = 1'b1;
                v.reason = REASON_MID;
            end
        end else if (tbl_lookup(TBL_REMOTE, h.ssrc) >= 0) begin
            v.pass   = 1'b1;
            v.reason = REASON_REMOTE;
        end else begin
            pt_ok = h.pt[6] ? pt_mask_hi_cfg[h.pt[5:0]] : pt_mask_lo_cfg[h.pt[5:0]];
            if (pt_ok) begin
                if (tbl_add(TBL_REMOTE, h.ssrc))
                    v.ovf = 1'b1;
                v.pass   = 1'b1;
                v.reason = REASON_PT;
            end
        end
        return v;
    endfunction

    function automatic logic [SSRC_W-1:0] pick_ssrc();
        if ($urandom_range(99) < 85)
            return ssrc_pool[$urandom_range(SSRC_POOL - 1)];
        return $urandom;
    endfunction

    task automatic push_hdr(logic func, logic [SSRC_W-1:0] ssrc, logic [PT_W-1:0] pt,
                            logic mp, logic [MID_W-1:0] mhi, logic [MID_W-1:0] mlo);
        t_hdr h;
        h.func        = func;
        h.ssrc        = ssrc;
        h.pt          = pt;
        h.mid_present = mp;
        h.mid_hi      = mhi;
        h.mid_lo      = mlo;
        hdr_q.push_back(h);
    endtask

    task automatic report_mismatch(string msg);
        if (err_cnt < MAX_REPORTS)
            $display("mismatch at result %0d: %s", res_cnt, msg);
        err_cnt++;
    endtask

    // one register write; the mirror follows at the handshake
    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        bit drop_bind;
        drop_bind = 1'b0;
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_MID_VALID: begin
                mid_vld_cfg = val[0];
                drop_bind   = 1'b1;
            end
            CFG_MID_HI: begin
                mid_hi_cfg = val;
                drop_bind  = 1'b1;
            end
            CFG_MID_LO: begin
                mid_lo_cfg = val;
                drop_bind  = 1'b1;
            end
            CFG_PT_MASK_HI: pt_mask_hi_cfg = val;
            CFG_PT_MASK_LO: pt_mask_lo_cfg = val;
            default: ;  // unused index, ignored
        endcase
        if (drop_bind)
            for (int i = 0; i < BOUND_ENTRIES; i++)
                tbl_vld[TBL_BOUND][i] = 1'b0;
    endtask

    // quiet: nothing queued, nothing offered, nothing owed
    task automatic wait_idle();
        do @(negedge i_clk);
        while (hdr_q.size() != 0 || s_axis_tvalid || verdict_q.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic set_idling(int mode);
        case (mode)
            0: begin
                tx_idle_pct  = 19;
                rx_stall_pct = 65;
            end
            1: begin
                tx_idle_pct  = 65;
                rx_stall_pct = 19;
            end
            default: begin
                tx_idle_pct  = 0;
                rx_stall_pct = 0;
            end
        endcase
    endtask

    // ---------------------------------------------------------------
    // Driver: offers queued headers, predicts at each accepted transaction
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                verdict_q.push_back(filter_decide(tx_hdr));
            if (!s_axis_tvalid || s_axis_tready) begin
                if (hdr_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                    tx_hdr = hdr_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {tx_hdr.mid_lo, tx_hdr.mid_hi, tx_hdr.mid_present,
                                      tx_hdr.pt, tx_hdr.ssrc};
                    s_axis_tuser  <= tx_hdr.func;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off, counted here
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rx_hold_left <= 0;
        end else if (rx_hold_go) begin
            rx_hold_left <= RX_HOLD_CYCLES;
        end else if (rx_hold_left != 0) begin
            rx_hold_left <= rx_hold_left - 1;
        end
    end

    // ---------------------------------------------------------------
    // Monitor: checks each result transaction against the oldest verdict
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (verdict_q.size() == 0) begin
                    report_mismatch("result with no header outstanding");
                end else begin
                    mon_exp = verdict_q.pop_front();
                    if (m_axis_tdata[0] !== mon_exp.pass)
                        report_mismatch($sformatf("pass %b, want %b",
                                                  m_axis_tdata[0], mon_exp.pass));
                    if (m_axis_tdata[2:1] !== mon_exp.reason)
                        report_mismatch($sformatf("match_reason %0d, want %0d",
                                                  m_axis_tdata[2:1], mon_exp.reason));
                    if (m_axis_tdata[3] !== mon_exp.ovf)
                        report_mismatch($sformatf("table_overflow %b, want %b",
                                                  m_axis_tdata[3], mon_exp.ovf));
                    if (m_axis_tdata[OUT_W-1:4] !== '0)
                        report_mismatch($sformatf("pad bits %b", m_axis_tdata[OUT_W-1:4]));
                end
                res_cnt++;
            end
            m_axis_tready <= (rx_hold_left == 0) && ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // ---------------------------------------------------------------
    // Stimulus: directed headers, then random phases under new settings
    // ---------------------------------------------------------------
    initial begin : stim
        int               n;
        int               burst;
        int               hit_pct;
        int               r;
        logic             mv;
        logic [SSRC_W-1:0] s;
        logic [PT_W-1:0]  pt;
        logic [MID_W-1:0] mh;
        logic [MID_W-1:0] ml;
        logic [CFG_DATA_W-1:0] val;

        ssrc_pool[0] = '0;
        ssrc_pool[1] = '1;
        for (int k = 2; k < SSRC_POOL; k++)
            ssrc_pool[k] = $urandom;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        set_idling(0);
        @(negedge i_clk);

        // all registers at reset: empty mask, no MID configured
        push_hdr(FUNC_FILTER, '0, '0, 1'b0, '0, '0);           // nothing accepts
        push_hdr(FUNC_FILTER, '0, '0, 1'b1, '0, '0);           // MID equal but not configured
        push_hdr(FUNC_ADD_REMOTE, '1, '1, 1'b1, '1, '1);
        push_hdr(FUNC_ADD_REMOTE, '1, '0, 1'b0, '0, '0);       // already present
        push_hdr(FUNC_FILTER, '1, '1, 1'b1, ALL_ONES, ALL_ONES); // known remote
        wait_idle();

        cfg_write(CFG_MID_VALID, {{(CFG_DATA_W-1){1'b1}}, 1'b1});
        cfg_write(CFG_MID_HI, ALL_ONES);
        cfg_write(CFG_MID_LO, ALL_ONES);
        cfg_write(CFG_PT_MASK_HI, 64'h8000_0000_0000_0000);   // payload type 127
        cfg_write(CFG_PT_MASK_LO, 64'h0000_0000_0000_0001);   // payload type 0
        for (int k = CFG_PT_MASK_LO + 1; k < (1 << CFG_IDX_W); k++)
            cfg_write(k[CFG_IDX_W-1:0], '1);
        @(negedge i_clk);

        push_hdr(FUNC_FILTER, 32'd1, 7'd0, 1'b0, '0, '0);      // learned on pt 0
        push_hdr(FUNC_FILTER, 32'd2, 7'd127, 1'b0, '0, '0);    // learned on pt 127
        push_hdr(FUNC_FILTER, 32'd3, 7'd64, 1'b0, '0, '0);     // mask edge, rejected
        push_hdr(FUNC_FILTER, 32'd3, 7'd63, 1'b0, '0, '0);
        push_hdr(FUNC_FILTER, 32'd10, 7'd5, 1'b1, ALL_ONES, ALL_ONES);  // bind
        push_hdr(FUNC_FILTER, 32'd1, 7'd0, 1'b0, '0, '0);      // binding exists, not bound
        push_hdr(FUNC_FILTER, 32'd10, 7'd1, 1'b1, ALL_ONES, '0); // moved MID: unbind
        push_hdr(FUNC_FILTER, 32'd1, 7'd5, 1'b0, '0, '0);      // remote again
        // fill the remote table, then overflow it both ways
        for (int k = 0; k < REMOTE_ENTRIES - 3; k++)
            push_hdr(FUNC_ADD_REMOTE, 32'h100 + k, '0, 1'b0, '0, '0);
        push_hdr(FUNC_ADD_REMOTE, 32'h200, '0, 1'b0, '0, '0);
        push_hdr(FUNC_FILTER, 32'h201, 7'd0, 1'b0, '0, '0);
        wait_idle();

        for (int p = 0; p < N_PHASES; p++) begin
            set_idling(p * 3 / N_PHASES);

            mv  = (p % 3 != 2);
            val = {$urandom, $urandom};
            val[0] = mv;
            cfg_write(CFG_MID_VALID, val);
            case (p)
                0: begin
                    mh = ALL_ONES;
                    ml = ALL_ONES;
                end
                1: begin
                    mh = '0;
                    ml = '0;
                end
                default: begin
                    mh = {$urandom, $urandom};
                    ml = {$urandom, $urandom};
                end
            endcase
            cfg_write(CFG_MID_HI, mh);
            cfg_write(CFG_MID_LO, ml);
            if (p == 0) begin
                cfg_write(CFG_PT_MASK_HI, '1);
                cfg_write(CFG_PT_MASK_LO, '1);
            end else if (p == 1) begin
                cfg_write(CFG_PT_MASK_HI, '0);
                cfg_write(CFG_PT_MASK_LO, '0);
            end else if (p % 2 == 1) begin
                cfg_write(CFG_PT_MASK_HI, {$urandom, $urandom} & {$urandom, $urandom});
                cfg_write(CFG_PT_MASK_LO, {$urandom, $urandom} & {$urandom, $urandom});
            end else begin
                cfg_write(CFG_PT_MASK_HI, {$urandom, $urandom});
                cfg_write(CFG_PT_MASK_LO, {$urandom, $urandom});
            end
            @(negedge i_clk);

            // streams: bursts of headers from one SSRC with a steady MID,
            // with adds of remote SSRCs sprinkled in
            hit_pct = $urandom_range(5, 60);
            n = 0;
            while (n < PHASE_ITEMS) begin
                if ($urandom_range(99) < 8) begin
                    push_hdr(FUNC_ADD_REMOTE, pick_ssrc(), PT_W'($urandom), 1'($urandom),
                             {$urandom, $urandom}, {$urandom, $urandom});
                    n++;
                end else begin
                    s  = pick_ssrc();
                    pt = PT_W'($urandom_range(127));
                    r  = $urandom_range(99);
                    mh = {$urandom, $urandom};
                    ml = {$urandom, $urandom};
                    if (r < hit_pct) begin
                        mh = mid_hi_cfg;
                        ml = mid_lo_cfg;
                    end else if (r < hit_pct + 10) begin
                        mh = mid_hi_cfg;
                    end else if (r < hit_pct + 20) begin
                        ml = mid_lo_cfg;
                    end
                    burst = $urandom_range(1, 6);
                    repeat (burst) begin
                        push_hdr(FUNC_FILTER, s, pt, ($urandom_range(99) < 70), mh, ml);
                        n++;
                    end
                end
            end

            // receiver goes away while headers keep coming
            if (p == HOLD_PHASE) begin
                repeat (40) @(negedge i_clk);
                @(posedge i_clk);
                rx_hold_go <= 1'b1;
                @(posedge i_clk);
                rx_hold_go <= 1'b0;
            end
            wait_idle();
        end

        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (err_cnt == 0 && verdict_q.size() == 0)
            $display("[rtp_stream_demux_filter_core] OK");
        else
            $display("[rtp_stream_demux_filter_core] ERROR");
        $finish;
    end

    initial begin
        #2000000;
        $display("[rtp_stream_demux_filter_core] ERROR");
        $finish;
    end

endmodule

`default_nettype wire

// ----- sim.f -----
+incdir+src
src/rsdf_pkg.sv
src/rsdf_match_unit.sv
src/rtp_stream_demux_filter_core.sv
tb/sv/testbench.sv
